>>> hdl/brl_pkg.sv
// ---------------------------------------------------------------------------
// brl_pkg: shared types and codes of the bitmap run allocator
// Result status codes, configuration register indexes and the per-byte
// step record passed from the byte step logic to the sequencer.
// ---------------------------------------------------------------------------
package brl_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_OVERLAP = 2'd2;
    localparam logic [1:0] ST_WRITTEN = 2'd3;

    localparam logic [1:0] CFG_MAP_BYTES = 2'd0;
    localparam logic [1:0] CFG_RUN_LEN   = 2'd1;
    localparam logic [1:0] CFG_OFFSET    = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    localparam logic [7:0] BYTE_FULL = 8'hFF;

    typedef struct packed {
        logic       full_byte;  // every bit of the byte is set
        logic [2:0] bit_lo;     // first bit that the run touches in this byte
        logic [7:0] wdata;      // byte value to write back
        logic       conflict;   // the run met a bit that is already set
        logic [3:0] nset;       // bits of the run that fall in this byte
        logic       done;       // the run completes in this byte
    } t_step;

endpackage

>>> hdl/brl_map_ram.sv
// ---------------------------------------------------------------------------
// brl_map_ram: bitmap byte store
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module brl_map_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/brl_byte_step.sv
// ---------------------------------------------------------------------------
// brl_byte_step: work on one bitmap byte
// Finds the first clear bit when the search is still open, and builds the
// byte that the run leaves behind, stopping short of any bit already set.
// ---------------------------------------------------------------------------
module brl_byte_step (
    input  logic               i_first,
    input  logic [7:0]         i_rdata,
    input  logic [13:0]        i_rem,
    output brl_pkg::t_step     o_step
);
    import brl_pkg::*;

    logic [2:0]  w_ffz;
    logic [2:0]  w_b;
    logic [3:0]  w_avail;
    logic [3:0]  w_k;
    logic [15:0] w_cand16;
    logic [7:0]  w_cand;
    logic [7:0]  w_hit;
    logic [7:0]  w_below;

    always_comb begin
        w_ffz = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!i_rdata[i]) begin
                w_ffz = 3'(i);
            end
        end
    end

    assign w_b     = i_first ? w_ffz : 3'd0;
    assign w_avail = 4'd8 - {1'b0, w_b};
    assign w_k     = (i_rem >= 14'(w_avail)) ? w_avail : i_rem[3:0];
    assign w_cand16 = ((16'd1 << w_k) - 16'd1) << w_b;
    assign w_cand  = w_cand16[7:0];
    assign w_hit   = i_rdata & w_cand;
    // Bits below the lowest clash; all ones when there is no clash.
    assign w_below = (w_hit - 8'd1) & ~w_hit;

    always_comb begin
        o_step.full_byte = (i_rdata == BYTE_FULL);
        o_step.bit_lo    = w_b;
        o_step.wdata     = i_rdata | (w_cand & w_below);
        o_step.conflict  = (w_hit != 8'd0);
        o_step.nset      = w_k;
        o_step.done      = (w_hit == 8'd0) && (i_rem == 14'(w_k));
    end

endmodule

>>> hdl/bitmap_run_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_run_allocator: first-fit run allocator over a byte-wide bitmap
// Write beats load one bitmap byte; allocate beats find the lowest clear bit
// and set a run of bits from there, returning its index plus an offset.
//
//   Channel   Dir   Handshake               Payload
//   s         in    i_s_tvalid/o_s_tready   tdata: addr, data; tuser: func
//   m         out   o_m_tvalid/i_m_tready   tdata: start_value; tuser: status
//   cfg       in    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A write beat passes from S_IDLE through S_DONE. An allocation steps in S_PROC
// over each full byte skipped and each byte the run touches, and reports FULL
// once the scan or the run reaches the end of the bytes in use; the bitmap RAM
// delivers one byte per cycle through its registered read port.
// After reset a clearing pass zeroes every bitmap byte; no input beat is taken
// meanwhile, configuration writes are. A result waiting in the output register
// does not stop the next beat being accepted; that beat's own result then
// waits in S_DONE until the register is free.
// ---------------------------------------------------------------------------
module bitmap_run_allocator #(
    parameter int MAP_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [9:0] byte_addr, [17:10] byte_data, zero pad
    input  logic        i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [25:0] start_value (signed), zero pad
    output logic [1:0]  o_m_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [24:0] i_cfg_data
);
    import brl_pkg::*;

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CW = $clog2(MAP_BYTES + 1);
    localparam int UW = (CW > 11) ? CW : 11;
    localparam int SW = AW + 3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROC,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_idx;
    logic          r_first;
    logic [13:0]   r_rem;
    logic [SW-1:0] r_start;
    logic [1:0]    r_res_status;
    logic [25:0]   r_res_value;
    logic          r_m_tvalid;
    logic [25:0]   r_m_value;
    logic [1:0]    r_m_status;
    logic [10:0]   r_cfg_map;
    logic [13:0]   r_cfg_run;
    logic [24:0]   r_cfg_off;

    logic          w_s_acc;
    logic          w_addr_ok;
    logic [CW-1:0] w_used;
    logic [CW-1:0] w_idx_inc;
    logic [7:0]    w_rdata;
    t_step         w_step;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [AW-1:0] w_raddr;
    logic [SW-1:0] w_start;
    logic [25:0]   w_value;
    logic          w_out_free;
    logic          w_past_end;
    logic          w_skip;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = {6'd0, r_m_value};
    assign o_m_tuser   = r_m_status;

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_addr_ok  = (17'(i_s_tdata[9:0]) < 17'(MAP_BYTES));
    assign w_used     = (UW'(r_cfg_map) > UW'(MAP_BYTES)) ? CW'(MAP_BYTES) : CW'(r_cfg_map);
    assign w_idx_inc  = r_idx + CW'(1);
    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign w_past_end = (r_idx >= w_used);
    assign w_skip     = r_first && w_step.full_byte;

    assign w_start = r_first ? {r_idx[AW-1:0], w_step.bit_lo} : r_start;
    assign w_value = 26'(w_start) + {r_cfg_off[24], r_cfg_off};

    brl_byte_step u_step (
        .i_first (r_first),
        .i_rdata (w_rdata),
        .i_rem   (r_rem),
        .o_step  (w_step)
    );

    // Write port: clearing pass, byte load, or the run's read-modify-write.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = 8'd0;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_IDLE: begin
                w_we    = w_s_acc && (i_s_tuser == FUNC_WRITE) && w_addr_ok;
                w_waddr = AW'(i_s_tdata[9:0]);
                w_wdata = i_s_tdata[17:10];
            end
            S_PROC: begin
                w_we    = !w_past_end && !w_skip;
                w_wdata = w_step.wdata;
            end
            S_DONE: begin
                w_we = 1'b0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Reads run one byte ahead, so the byte at r_idx is at the port in S_PROC.
    assign w_raddr = (r_state == S_IDLE) ? AW'(0) : w_idx_inc[AW-1:0];

    brl_map_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_map <= 11'd1024;
            r_cfg_run <= 14'd1;
            r_cfg_off <= 25'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_BYTES: r_cfg_map <= i_cfg_data[10:0];
                CFG_RUN_LEN:   r_cfg_run <= i_cfg_data[13:0];
                CFG_OFFSET:    r_cfg_off <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_first    <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded below instead.
            if (r_m_tvalid && i_m_tready && (r_state != S_DONE)) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_idx == CW'(MAP_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= w_idx_inc;
                    end
                end
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_idx        <= '0;
                        r_first      <= 1'b1;
                        r_rem        <= (r_cfg_run == 14'd0) ? 14'd1 : r_cfg_run;
                        r_res_status <= ST_WRITTEN;
                        r_res_value  <= 26'd0;
                        r_state      <= (i_s_tuser == FUNC_ALLOC) ? S_PROC : S_DONE;
                    end
                end
                S_PROC: begin
                    if (w_past_end) begin
                        r_res_status <= ST_FULL;
                        r_res_value  <= 26'd0;
                        r_state      <= S_DONE;
                    end else if (w_skip) begin
                        r_idx <= w_idx_inc;
                    end else begin
                        r_first <= 1'b0;
                        r_start <= w_start;
                        if (w_step.conflict) begin
                            r_res_status <= ST_OVERLAP;
                            r_res_value  <= 26'd0;
                            r_state      <= S_DONE;
                        end else if (w_step.done) begin
                            r_res_status <= ST_OK;
                            r_res_value  <= w_value;
                            r_state      <= S_DONE;
                        end else begin
                            r_rem <= r_rem - 14'(w_step.nset);
                            r_idx <= w_idx_inc;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_value  <= r_res_value;
                        r_m_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A failed or write result never carries a start value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && (r_m_status != ST_OK)) |-> (r_m_value == 26'd0))
        else $error("non-zero start value on a result that is not an allocation");

    // The run always has bits left to set while it is being worked on.
    a_rem_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROC) |-> (r_rem != 14'd0))
        else $error("run length exhausted while allocating");

    // The run never writes a byte outside the bytes in use.
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PROC) && w_we) |-> (r_idx < w_used))
        else $error("run wrote beyond the bytes in use");

    // The clearing pass runs to the last byte before the block opens.
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && (r_idx != CW'(MAP_BYTES - 1))) |=> (r_state == S_CLEAR))
        else $error("clearing pass left early");

    // An accepted beat always starts work.
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state != S_IDLE))
        else $error("accepted beat did not start work");

endmodule
